// ===== rtl/slr_pkg.sv =====
// slr_pkg: shared types, constants and codes of the sliding-window-log rate limiter
// no dependencies; every other file of the block but slr_stamp_mem refers to it by scoped names
`timescale 1ns / 1ps

package slr_pkg;

  // fixed field widths of the channels and the configuration registers
  localparam int UserW     = 4;
  localparam int NowW      = 32;
  localparam int LimitW    = 4;
  localparam int WindowW   = 31;
  localparam int InWindowW = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;

  // parameter defaults
  localparam int DefUserCount = 16;
  localparam int DefLogDepth  = 8;
  localparam int DefTimeBits  = 32;

  // register reset values
  localparam logic [LimitW-1:0]  LimitReset  = LimitW'(5);
  localparam logic [WindowW-1:0] WindowReset = WindowW'(2000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REQUEST_LIMIT = 2'd0,
    CFG_WINDOW_TICKS  = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_CHECK,
    ST_DECIDE
  } slr_state_e;

  typedef struct packed {
    logic [LimitW-1:0]  request_limit;
    logic [WindowW-1:0] window_ticks;
  } slr_cfg_t;

endpackage

// ===== rtl/slr_if.sv =====
// slr_if: valid/ready channel interfaces for requests, responses and register writes
// depends on slr_pkg for the field widths
`timescale 1ns / 1ps

interface slr_req_if;
  logic                       valid;
  logic                       ready;
  logic [slr_pkg::UserW-1:0]  user;
  logic [slr_pkg::NowW-1:0]   now_time;

  modport source (output valid, output user, output now_time, input ready);
  modport sink   (input valid, input user, input now_time, output ready);
endinterface

interface slr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          allowed;
  logic [slr_pkg::InWindowW-1:0] in_window;

  modport source (output valid, output allowed, output in_window, input ready);
  modport sink   (input valid, input allowed, input in_window, output ready);
endinterface

interface slr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [slr_pkg::CfgIdxW-1:0]  index;
  logic [slr_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/slr_stamp_mem.sv =====
// slr_stamp_mem: single-port stamp memory, one shared address, one write and one read per cycle
// read data registered; contents undefined until written
`timescale 1ns / 1ps

module slr_stamp_mem #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/slr_age_cmp.sv =====
// slr_age_cmp: modular age of a logged stamp and its compare against the window
// depends on slr_pkg for the window width
`timescale 1ns / 1ps

module slr_age_cmp #(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0]         now_i,
  input  logic [TIME_BITS-1:0]         stamp_i,
  input  logic [slr_pkg::WindowW-1:0]  window_i,
  output logic                         expired_o
);

  localparam int CmpW = (TIME_BITS > slr_pkg::WindowW) ? TIME_BITS : slr_pkg::WindowW;

  logic [TIME_BITS-1:0] age;

  // wraps modulo 2^TIME_BITS, so a stamp ahead of now looks old
  assign age       = now_i - stamp_i;
  assign expired_o = CmpW'(age) >= CmpW'(window_i);

endmodule

// ===== rtl/slr_ctrl.sv =====
// slr_ctrl: sequencer that expires, checks and logs one request at a time
// depends on slr_pkg, slr_if and slr_age_cmp; drives the stamp memory port
`timescale 1ns / 1ps

module slr_ctrl #(
  parameter int USER_COUNT = slr_pkg::DefUserCount,
  parameter int LOG_DEPTH  = slr_pkg::DefLogDepth,
  parameter int TIME_BITS  = slr_pkg::DefTimeBits,
  parameter int MEM_AW     = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slr_pkg::slr_cfg_t     cfg_i,
  slr_req_if.sink               req_i,
  slr_rsp_if.source             rsp_o,
  output logic                  mem_we_o,
  output logic                  mem_re_o,
  output logic [MEM_AW-1:0]     mem_addr_o,
  output logic [TIME_BITS-1:0]  mem_wdata_o,
  input  logic [TIME_BITS-1:0]  mem_rdata_i
);

  localparam int MaxUsers  = 1 << slr_pkg::UserW;
  localparam int UsedUsers = (USER_COUNT < MaxUsers) ? USER_COUNT : MaxUsers;
  localparam int UW        = (UsedUsers > 1) ? $clog2(UsedUsers) : 1;
  localparam int SW        = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CW        = $clog2(LOG_DEPTH + 1);
  localparam int SumW      = SW + 1;

  slr_pkg::slr_state_e state_q, state_d;

  logic [UW-1:0]        user_q, user_d;
  logic                 bad_q, bad_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [SW-1:0]        head_q, head_d;
  logic [CW-1:0]        cnt_q, cnt_d;

  logic                            rsp_valid_q, rsp_valid_d;
  logic                            rsp_allowed_q, rsp_allowed_d;
  logic [slr_pkg::InWindowW-1:0]   rsp_cnt_q, rsp_cnt_d;

  logic [SW-1:0] oldest_q [UsedUsers];
  logic [CW-1:0] count_q  [UsedUsers];

  logic            req_fire;
  logic            decide_go;
  logic            expired;
  logic            allow;
  logic            table_we;
  logic [CW-1:0]   lim;
  logic [CW-1:0]   cnt_new;
  logic [SumW-1:0] head_inc;
  logic [SumW-1:0] tail_sum;
  logic [SW-1:0]   head_next;
  logic [SW-1:0]   tail;
  logic [SW-1:0]   slot;

  slr_age_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_age_cmp (
    .now_i     (now_q),
    .stamp_i   (mem_rdata_i),
    .window_i  (cfg_i.window_ticks),
    .expired_o (expired)
  );

  assign req_fire  = req_i.valid && req_i.ready;
  assign decide_go = (state_q == slr_pkg::ST_DECIDE) && (!rsp_valid_q || rsp_o.ready);

  // limit saturates at the log depth
  assign lim   = (32'(cfg_i.request_limit) > LOG_DEPTH) ? CW'(LOG_DEPTH)
                                                      : CW'(cfg_i.request_limit);
  assign allow = !bad_q && (cnt_q < lim);
  assign cnt_new = allow ? cnt_q + CW'(1) : cnt_q;

  assign head_inc  = SumW'(head_q) + SumW'(1);
  assign head_next = (32'(head_inc) >= LOG_DEPTH) ? '0 : SW'(head_inc);
  assign tail_sum  = SumW'(head_q) + SumW'(cnt_q);
  assign tail      = (32'(tail_sum) >= LOG_DEPTH) ? SW'(tail_sum - SumW'(LOG_DEPTH))
                                                  : SW'(tail_sum);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slr_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_d = (32'(req_i.user) >= USER_COUNT) ? slr_pkg::ST_DECIDE : slr_pkg::ST_LOAD;
        end
      end
      slr_pkg::ST_LOAD: state_d = slr_pkg::ST_READ;
      slr_pkg::ST_READ: begin
        state_d = (cnt_q == '0) ? slr_pkg::ST_DECIDE : slr_pkg::ST_CHECK;
      end
      slr_pkg::ST_CHECK: begin
        state_d = expired ? slr_pkg::ST_READ : slr_pkg::ST_DECIDE;
      end
      slr_pkg::ST_DECIDE: begin
        if (decide_go) begin
          state_d = slr_pkg::ST_IDLE;
        end
      end
      default: state_d = slr_pkg::ST_IDLE;
    endcase
  end

  // outputs to the channels and the memory
  always_comb begin
    req_i.ready = (state_q == slr_pkg::ST_IDLE);
    mem_re_o    = (state_q == slr_pkg::ST_READ) && (cnt_q != '0);
    mem_we_o    = decide_go && allow;
    slot        = (state_q == slr_pkg::ST_DECIDE) ? tail : head_q;
    mem_addr_o  = MEM_AW'(32'(user_q) * LOG_DEPTH + 32'(slot));
    mem_wdata_o = now_q;
    table_we    = decide_go && !bad_q;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.allowed   = rsp_allowed_q;
  assign rsp_o.in_window = rsp_cnt_q;

  // datapath next values
  always_comb begin
    user_d        = user_q;
    bad_d         = bad_q;
    now_d         = now_q;
    head_d        = head_q;
    cnt_d         = cnt_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    rsp_allowed_d = rsp_allowed_q;
    rsp_cnt_d     = rsp_cnt_q;
    if (req_fire) begin
      user_d = UW'(req_i.user);
      bad_d  = 32'(req_i.user) >= USER_COUNT;
      now_d  = TIME_BITS'(req_i.now_time);
    end
    if (state_q == slr_pkg::ST_LOAD) begin
      head_d = oldest_q[user_q];
      cnt_d  = count_q[user_q];
    end
    // drop the oldest stamp and move on
    if ((state_q == slr_pkg::ST_CHECK) && expired) begin
      head_d = head_next;
      cnt_d  = cnt_q - CW'(1);
    end
    if (decide_go) begin
      rsp_valid_d   = 1'b1;
      rsp_allowed_d = allow;
      rsp_cnt_d     = bad_q ? '0 : slr_pkg::InWindowW'(cnt_new);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slr_pkg::ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    user_q        <= user_d;
    bad_q         <= bad_d;
    now_q         <= now_d;
    head_q        <= head_d;
    cnt_q         <= cnt_d;
    rsp_allowed_q <= rsp_allowed_d;
    rsp_cnt_q     <= rsp_cnt_d;
  end

  // per-user ring heads and fill counts, all logs empty after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < UsedUsers; i++) begin
        oldest_q[i] <= '0;
        count_q[i]  <= '0;
      end
    end else if (table_we) begin
      oldest_q[user_q] <= head_q;
      count_q[user_q]  <= cnt_new;
    end
  end

endmodule

// ===== rtl/sliding_log_rate_limiter_unit.sv =====
// sliding_log_rate_limiter_unit: top level with the configuration registers
// depends on slr_pkg, slr_if, slr_stamp_mem and slr_ctrl
`timescale 1ns / 1ps

// Per-user sliding-window-log rate limiter. Each request item names a user and the
// current time; the user's oldest logged stamps are dropped while their age
// (now_time - stamp, modulo 2^TIME_BITS) is at least window_ticks, then the request
// is allowed and logged if fewer than request_limit stamps remain (the limit saturates
// at LOG_DEPTH). Users at or above USER_COUNT are denied with in_window = 0. One item
// is worked at a time: after acceptance the block loads the user's log head and fill
// count, then reads and compares its stamps one at a time, oldest first, until one is
// live or the log is empty (at most LOG_DEPTH stamps are examined), because every
// stamp goes through the single memory read port and the one age comparator; then it
// decides and logs. An unknown user goes straight to the decision.
// The result sits in an output register, so the next item is taken while it waits,
// and work on that item only stalls at its end if the previous result is still held.
// All logs are empty after reset. Registers are to be written only while the block
// is idle; the block itself does not enforce it.
module sliding_log_rate_limiter_unit #(
  parameter int USER_COUNT = slr_pkg::DefUserCount,
  parameter int LOG_DEPTH  = slr_pkg::DefLogDepth,
  parameter int TIME_BITS  = slr_pkg::DefTimeBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slr_req_if.sink    req_i,
  slr_rsp_if.source  rsp_o,
  slr_cfg_if.sink    cfg_i
);

  localparam int MaxUsers  = 1 << slr_pkg::UserW;
  localparam int UsedUsers = (USER_COUNT < MaxUsers) ? USER_COUNT : MaxUsers;
  localparam int MemDepth  = UsedUsers * LOG_DEPTH;
  localparam int MemAw     = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  logic [slr_pkg::LimitW-1:0]  request_limit_q, request_limit_d;
  logic [slr_pkg::WindowW-1:0] window_ticks_q, window_ticks_d;
  slr_pkg::slr_cfg_t           cfg;

  logic                 mem_we;
  logic                 mem_re;
  logic [MemAw-1:0]     mem_addr;
  logic [TIME_BITS-1:0] mem_wdata;
  logic [TIME_BITS-1:0] mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    request_limit_d = request_limit_q;
    window_ticks_d  = window_ticks_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (slr_pkg::cfg_reg_e'(cfg_i.index))
        slr_pkg::CFG_REQUEST_LIMIT: request_limit_d = slr_pkg::LimitW'(cfg_i.data);
        slr_pkg::CFG_WINDOW_TICKS:  window_ticks_d  = slr_pkg::WindowW'(cfg_i.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      request_limit_q <= slr_pkg::LimitReset;
      window_ticks_q  <= slr_pkg::WindowReset;
    end else begin
      request_limit_q <= request_limit_d;
      window_ticks_q  <= window_ticks_d;
    end
  end

  assign cfg.request_limit = request_limit_q;
  assign cfg.window_ticks  = window_ticks_q;

  slr_ctrl #(
    .USER_COUNT (USER_COUNT),
    .LOG_DEPTH  (LOG_DEPTH),
    .TIME_BITS  (TIME_BITS),
    .MEM_AW     (MemAw)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  slr_stamp_mem #(
    .DEPTH  (MemDepth),
    .ADDR_W (MemAw),
    .DATA_W (TIME_BITS)
  ) u_stamp_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== rtl/slr_checker.sv =====
// slr_checker: port-level assertions for the rate limiter, bound to the top level
// depends on slr_pkg for widths; attached by the bind at the end of this file
`timescale 1ns / 1ps

module slr_checker #(
  parameter int LOG_DEPTH = slr_pkg::DefLogDepth
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          rsp_allowed_i,
  input logic [slr_pkg::InWindowW-1:0] rsp_in_window_i
);

  // one item at a time: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous item is still in work");

  // a new result only comes out of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i))
    else $error("result appeared without an item in work");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_allowed_i) && $stable(rsp_in_window_i))
    else $error("stalled result changed or dropped");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> 32'(rsp_in_window_i) <= LOG_DEPTH)
    else $error("log count above log depth");

endmodule

bind sliding_log_rate_limiter_unit slr_checker #(
  .LOG_DEPTH (LOG_DEPTH)
) u_slr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_allowed_i   (rsp_o.allowed),
  .rsp_in_window_i (rsp_o.in_window)
);

// ===== tb/sliding_log_rate_limiter_unit_tb.sv =====
// sliding_log_rate_limiter_unit_tb: self-checking testbench of the per-user sliding-window-log
// rate limiter; predicts every verdict and compares it with the response channel
// depends on slr_pkg, slr_if and the sliding_log_rate_limiter_unit rtl
`timescale 1ns / 1ps

module sliding_log_rate_limiter_unit_tb;

  localparam int UserCount  = slr_pkg::DefUserCount;
  localparam int LogDepth   = slr_pkg::DefLogDepth;
  localparam int CycleLimit = 400000;
  localparam int LongHold   = 300;
  localparam logic [slr_pkg::CfgIdxW-1:0] CfgUnusedIdx = 2'd3;

  typedef struct {
    logic [slr_pkg::UserW-1:0] user;
    logic [slr_pkg::NowW-1:0]  now_time;
  } request_t;

  typedef struct {
    logic                          allowed;
    logic [slr_pkg::InWindowW-1:0] in_window;
  } verdict_t;

  logic clk;
  logic rst_n;

  slr_req_if req_if ();
  slr_rsp_if rsp_if ();
  slr_cfg_if cfg_if ();

  sliding_log_rate_limiter_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // predicted per-user logs and register copies
  logic [slr_pkg::NowW-1:0]    log_stamp [UserCount][LogDepth];
  int                          log_head  [UserCount];
  int                          log_fill  [UserCount];
  logic [slr_pkg::LimitW-1:0]  cur_limit;
  logic [slr_pkg::WindowW-1:0] cur_window;

  request_t request_backlog[$];
  verdict_t rate_verdicts[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_requests;
  int  holds_served;
  int  hold_left;
  int  mismatches;
  int  cycle_count;
  bit  req_taken;
  bit  cfg_taken;
  bit  window_msb;
  logic [slr_pkg::NowW-1:0] sim_ticks;

  function automatic verdict_t rate_decide(input request_t r);
    verdict_t v;
    int hd;
    int n;
    int cap;
    hd = log_head[r.user];
    n  = log_fill[r.user];
    // expire oldest stamps, age taken modulo 2^32
    while (n != 0 && (r.now_time - log_stamp[r.user][hd]) >= {1'b0, cur_window}) begin
      hd = (hd + 1) % LogDepth;
      n--;
    end
    cap = (cur_limit > LogDepth) ? LogDepth : int'(cur_limit);
    v.allowed = 1'b0;
    if (n < cap) begin
      log_stamp[r.user][(hd + n) % LogDepth] = r.now_time;
      n++;
      v.allowed = 1'b1;
    end
    log_head[r.user] = hd;
    log_fill[r.user] = n;
    v.in_window = slr_pkg::InWindowW'(n);
    return v;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  task automatic queue_request(input int user, input logic [slr_pkg::NowW-1:0] t);
    request_t r;
    r.user     = slr_pkg::UserW'(user);
    r.now_time = t;
    request_backlog.insert(request_backlog.size(), r);
  endtask

  task automatic wait_drained();
    while (request_backlog.size() != 0 || req_if.valid || rate_verdicts.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [slr_pkg::CfgIdxW-1:0] idx,
                           input logic [slr_pkg::CfgDataW-1:0] val);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [slr_pkg::LimitW-1:0] lim,
                           input logic [slr_pkg::WindowW-1:0] win,
                           input int count, input int send_pct, input int recv_pct,
                           input bit long_hold);
    logic [31:0] span;
    int hot_a;
    int hot_b;
    int user;
    write_reg(slr_pkg::CFG_REQUEST_LIMIT, {28'($urandom()), lim});
    write_reg(slr_pkg::CFG_WINDOW_TICKS, {window_msb, win});
    window_msb     = ~window_msb;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    span      = (win < 31'd24) ? 32'd2 : {1'b0, win} / 12;
    hot_a     = $urandom_range(UserCount - 1);
    hot_b     = $urandom_range(UserCount - 1);
    sim_ticks = $urandom();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 85) begin
        // steady time with two busy users so logs fill and age out
        sim_ticks += $urandom_range(span);
        if ($urandom_range(99) < 70) user = $urandom_range(1) ? hot_a : hot_b;
        else user = $urandom_range(UserCount - 1);
        queue_request(user, sim_ticks);
      end else begin
        // noise: arbitrary times look like future stamps to other users
        queue_request($urandom_range(UserCount - 1), $urandom());
      end
    end
    if (long_hold) hold_requests++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("sliding_log_rate_limiter_unit regression: fail");
      $finish;
    end
  end

  // monitor: checks responses, predicts accepted requests, tracks register writes
  always @(posedge clk) begin
    verdict_t want;
    request_t got;
    req_taken = req_if.valid && req_if.ready;
    cfg_taken = cfg_if.valid && cfg_if.ready;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rate_verdicts.size() == 0) begin
          note_mismatch($sformatf("unexpected response allowed=%0d in_window=%0d",
                                  rsp_if.allowed, rsp_if.in_window));
        end else begin
          want = rate_verdicts[0];
          rate_verdicts.delete(0);
          if (rsp_if.allowed !== want.allowed)
            note_mismatch($sformatf("allowed expected %0d got %0d",
                                    want.allowed, rsp_if.allowed));
          if (rsp_if.in_window !== want.in_window)
            note_mismatch($sformatf("in_window expected %0d got %0d",
                                    want.in_window, rsp_if.in_window));
        end
      end
      if (cfg_taken) begin
        case (slr_pkg::cfg_reg_e'(cfg_if.index))
          slr_pkg::CFG_REQUEST_LIMIT: cur_limit  = cfg_if.data[slr_pkg::LimitW-1:0];
          slr_pkg::CFG_WINDOW_TICKS:  cur_window = cfg_if.data[slr_pkg::WindowW-1:0];
          default: ;
        endcase
      end
      if (req_taken) begin
        got.user     = req_if.user;
        got.now_time = req_if.now_time;
        rate_verdicts.insert(rate_verdicts.size(), rate_decide(got));
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    request_t nxt;
    if (rst_n && (!req_if.valid || req_taken)) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = request_backlog[0];
        request_backlog.delete(0);
        req_if.valid    <= 1'b1;
        req_if.user     <= nxt.user;
        req_if.now_time <= nxt.now_time;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    req_if.valid    = 1'b0;
    req_if.user     = '0;
    req_if.now_time = '0;
    rsp_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    cur_limit       = slr_pkg::LimitReset;
    cur_window      = slr_pkg::WindowReset;
    for (int u = 0; u < UserCount; u++) begin
      log_head[u] = 0;
      log_fill[u] = 0;
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    window_msb     = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed items under the reset settings: limit 5, window 2000
    repeat (6) queue_request(0, 32'd0);
    queue_request(0, 32'd1999);
    queue_request(0, 32'd2000);
    queue_request(15, 32'hFFFF_FFFF);
    queue_request(15, 32'd5);
    queue_request(15, 32'hFFFF_FF00);
    queue_request(10, 32'h7FFF_FFFF);
    queue_request(5, 32'h8000_0000);
    queue_request(1, 32'hAAAA_AAAA);
    queue_request(2, 32'h5555_5555);
    queue_request(3, 32'd100);
    queue_request(3, 32'd2099);
    queue_request(3, 32'd2100);

    run_phase(4'd8,  31'd100,        110, 0,  0,  1'b0);
    run_phase(4'd0,  31'd50,         60,  49, 0,  1'b0);
    run_phase(4'd15, 31'd300,        110, 0,  49, 1'b0);
    run_phase(4'd1,  31'd0,          100, 19, 19, 1'b0);
    run_phase(4'd3,  31'h7FFF_FFFF,  110, 0,  0,  1'b1);
    write_reg(CfgUnusedIdx, $urandom());
    run_phase(4'd4,  31'd1,          110, 49, 0,  1'b0);
    run_phase(4'd6,  31'd40,         120, 0,  49, 1'b0);
    run_phase(4'd8,  31'd2000,       120, 19, 19, 1'b0);
    run_phase(4'd2,  31'd500,        110, 0,  0,  1'b1);
    run_phase(4'd7,  31'd20,         110, 49, 0,  1'b0);

    wait_drained();
    repeat (30) @(negedge clk);
    if (mismatches == 0 && rate_verdicts.size() == 0) begin
      $display("sliding_log_rate_limiter_unit regression: pass");
    end else begin
      $display("sliding_log_rate_limiter_unit regression: fail");
    end
    $finish;
  end

endmodule
